/* design/wdsa_pkg.sv */
package wdsa_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 3;
  localparam int unsigned ADDRESS_BITS_DEF  = 16;

  localparam int unsigned NOW_W      = 32;
  localparam int unsigned TIMEOUT_W  = 31;
  localparam int unsigned SRC_PORT_W = 16;
  localparam int unsigned OUT_CNT_W  = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd3840;

  localparam logic ACT_EVENT = 1'b0;
  localparam logic ACT_CHECK = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH,
    ST_CHECK
  } state_e;

endpackage

/* design/wdsa_age_cmp.sv */
// Shared age unit: wrapping difference now - ref, compared against timeout.
module wdsa_age_cmp (
  input  logic [wdsa_pkg::NOW_W-1:0]     now_i,
  input  logic [wdsa_pkg::NOW_W-1:0]     ref_i,
  input  logic [wdsa_pkg::TIMEOUT_W-1:0] timeout_i,
  output logic                           expired_o
);

  logic [wdsa_pkg::NOW_W-1:0] age;

  assign age       = now_i - ref_i;
  assign expired_o = age > {1'b0, timeout_i};

endmodule

/* design/wdsa_hist.sv */
// History entries: one read port and one write port, no reset on payload.
module wdsa_hist #(
  parameter int unsigned DEPTH = wdsa_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned SRC_W = wdsa_pkg::SRC_PORT_W,
  parameter int unsigned IDX_W = 2
) (
  input  logic                       clk_i,
  input  logic [IDX_W-1:0]           rd_idx_i,
  output logic [wdsa_pkg::NOW_W-1:0] rd_time_o,
  output logic [SRC_W-1:0]           rd_src_o,
  input  logic                       we_i,
  input  logic [IDX_W-1:0]           wr_idx_i,
  input  logic [wdsa_pkg::NOW_W-1:0] wr_time_i,
  input  logic [SRC_W-1:0]           wr_src_i
);

  logic [wdsa_pkg::NOW_W-1:0] time_q [DEPTH];
  logic [SRC_W-1:0]           src_q  [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      time_q[wr_idx_i] <= wr_time_i;
      src_q[wr_idx_i]  <= wr_src_i;
    end
  end

  assign rd_time_o = time_q[rd_idx_i];
  assign rd_src_o  = src_q[rd_idx_i];

endmodule

/* design/windowed_distinct_source_alarm.sv */
// Channel   Signals                                          Handshake
// -------   ----------------------------------------------   ------------------------
// request   action_i, now_i, source_address_i                start_i & !busy_o
// config    cfg_data_i (timeout_ticks)                       cfg_valid_i & cfg_ready_o
// result    alarm_o, entry_count_o, event_added_o,           done_o, one cycle
//           expired_removed_o
//
// An event request keeps busy_o high while each stored entry passes through the shared
// age compare unit, then for scan end and append; a check holds it for ST_CHECK only.
// The result strobe comes in the first cycle with busy_o low; a new request may be
// taken in that cycle.
// The receiver cannot stall results.
// Reset clears the history count, last activity time and alarm; timeout loads 3840.
module windowed_distinct_source_alarm #(
  parameter int unsigned HISTORY_DEPTH = wdsa_pkg::HISTORY_DEPTH_DEF,
  parameter int unsigned ADDRESS_BITS  = wdsa_pkg::ADDRESS_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                action_i,
  input  logic [wdsa_pkg::NOW_W-1:0]          now_i,
  input  logic [wdsa_pkg::SRC_PORT_W-1:0]     source_address_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [wdsa_pkg::TIMEOUT_W-1:0]      cfg_data_i,
  output logic                                done_o,
  output logic                                alarm_o,
  output logic [wdsa_pkg::OUT_CNT_W-1:0]      entry_count_o,
  output logic                                event_added_o,
  output logic [wdsa_pkg::OUT_CNT_W-1:0]      expired_removed_o
);

  localparam int unsigned SRC_W = (ADDRESS_BITS < wdsa_pkg::SRC_PORT_W) ?
                                  ADDRESS_BITS : wdsa_pkg::SRC_PORT_W;
  localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int unsigned IDX_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(HISTORY_DEPTH);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

  wdsa_pkg::state_e state_q, state_d;

  logic [wdsa_pkg::TIMEOUT_W-1:0] timeout_q;
  logic [wdsa_pkg::NOW_W-1:0]     now_q;
  logic [SRC_W-1:0]               src_q;
  logic [wdsa_pkg::NOW_W-1:0]     last_q, last_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic [CNT_W-1:0]               scan_q, scan_d;
  logic [CNT_W-1:0]               kept_q, kept_d;
  logic [CNT_W-1:0]               removed_q, removed_d;
  logic                           present_q, present_d;
  logic                           added_q, added_d;
  logic                           alarm_q, alarm_d;
  logic                           done_q, done_d;

  logic                           accept;
  logic                           hist_we;
  logic [IDX_W-1:0]               hist_wr_idx;
  logic [wdsa_pkg::NOW_W-1:0]     hist_wr_time;
  logic [wdsa_pkg::NOW_W-1:0]     rd_time;
  logic [SRC_W-1:0]               rd_src;
  logic [wdsa_pkg::NOW_W-1:0]     cmp_ref;
  logic                           expired;
  logic [CNT_W+1:0]               count_ext;
  logic [CNT_W+1:0]               removed_ext;

  assign accept      = start_i && (state_q == wdsa_pkg::ST_IDLE);
  assign busy_o      = state_q != wdsa_pkg::ST_IDLE;
  assign cfg_ready_o = 1'b1;

  // single age compare shared by the scan and the inactivity check
  assign cmp_ref = (state_q == wdsa_pkg::ST_CHECK) ? last_q : rd_time;

  wdsa_age_cmp u_age_cmp (
    .now_i     (now_q),
    .ref_i     (cmp_ref),
    .timeout_i (timeout_q),
    .expired_o (expired)
  );

  wdsa_hist #(
    .DEPTH (HISTORY_DEPTH),
    .SRC_W (SRC_W),
    .IDX_W (IDX_W)
  ) u_hist (
    .clk_i     (clk_i),
    .rd_idx_i  (scan_q[IDX_W-1:0]),
    .rd_time_o (rd_time),
    .rd_src_o  (rd_src),
    .we_i      (hist_we),
    .wr_idx_i  (hist_wr_idx),
    .wr_time_i (hist_wr_time),
    .wr_src_i  ((state_q == wdsa_pkg::ST_SCAN) ? rd_src : src_q)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wdsa_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = (action_i == wdsa_pkg::ACT_CHECK) ? wdsa_pkg::ST_CHECK
                                                       : wdsa_pkg::ST_SCAN;
        end
      end
      wdsa_pkg::ST_SCAN: begin
        if (scan_q == count_q) state_d = wdsa_pkg::ST_FINISH;
      end
      wdsa_pkg::ST_FINISH: state_d = wdsa_pkg::ST_IDLE;
      wdsa_pkg::ST_CHECK:  state_d = wdsa_pkg::ST_IDLE;
      default:             state_d = wdsa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    last_d       = last_q;
    count_d      = count_q;
    scan_d       = scan_q;
    kept_d       = kept_q;
    removed_d    = removed_q;
    present_d    = present_q;
    added_d      = added_q;
    alarm_d      = alarm_q;
    done_d       = 1'b0;
    hist_we      = 1'b0;
    hist_wr_idx  = kept_q[IDX_W-1:0];
    hist_wr_time = now_q;
    unique case (state_q)
      wdsa_pkg::ST_IDLE: begin
        if (start_i) begin
          scan_d    = '0;
          kept_d    = '0;
          removed_d = '0;
          present_d = 1'b0;
          added_d   = 1'b0;
        end
      end
      wdsa_pkg::ST_SCAN: begin
        if (scan_q != count_q) begin
          scan_d = scan_q + CNT_ONE;
          if (expired) begin
            removed_d = removed_q + CNT_ONE;
          end else begin
            // survivor packs down to the next kept slot
            hist_we      = 1'b1;
            hist_wr_time = rd_time;
            kept_d       = kept_q + CNT_ONE;
            if (rd_src == src_q) present_d = 1'b1;
          end
        end
      end
      wdsa_pkg::ST_FINISH: begin
        last_d  = now_q;
        count_d = kept_q;
        done_d  = 1'b1;
        if (!present_q && (kept_q < DEPTH_CNT)) begin
          hist_we = 1'b1;
          count_d = kept_q + CNT_ONE;
          added_d = 1'b1;
          if (kept_q + CNT_ONE == DEPTH_CNT) alarm_d = 1'b1;
        end else if (kept_q == DEPTH_CNT) begin
          alarm_d = 1'b1;
        end
      end
      wdsa_pkg::ST_CHECK: begin
        done_d = 1'b1;
        if ((count_q != '0) && expired) alarm_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wdsa_pkg::ST_IDLE;
      timeout_q <= wdsa_pkg::TIMEOUT_RESET;
      last_q    <= '0;
      count_q   <= '0;
      scan_q    <= '0;
      kept_q    <= '0;
      removed_q <= '0;
      present_q <= 1'b0;
      added_q   <= 1'b0;
      alarm_q   <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      if (cfg_valid_i) timeout_q <= cfg_data_i;
      last_q    <= last_d;
      count_q   <= count_d;
      scan_q    <= scan_d;
      kept_q    <= kept_d;
      removed_q <= removed_d;
      present_q <= present_d;
      added_q   <= added_d;
      alarm_q   <= alarm_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= now_i;
      src_q <= source_address_i[SRC_W-1:0];
    end
  end

  assign count_ext   = {2'b00, count_q};
  assign removed_ext = {2'b00, removed_q};

  assign done_o            = done_q;
  assign alarm_o           = alarm_q;
  assign entry_count_o     = count_ext[wdsa_pkg::OUT_CNT_W-1:0];
  assign event_added_o     = added_q;
  assign expired_removed_o = removed_ext[wdsa_pkg::OUT_CNT_W-1:0];

endmodule

/* test/windowed_distinct_source_alarm_test.sv */
module windowed_distinct_source_alarm_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HDEPTH        = wdsa_pkg::HISTORY_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned LIMIT_CYCLES  = 200000;
  localparam int unsigned PHASES        = 6;
  localparam int unsigned PHASE_ITEMS   = 105;

  typedef struct packed {
    logic       alarm;
    logic [1:0] entry_count;
    logic       event_added;
    logic [1:0] expired_removed;
  } alarm_result_t;

  typedef struct packed {
    logic                       action;
    logic [wdsa_pkg::NOW_W-1:0] now;
    logic [15:0]                src;
    logic                       pinned;
    alarm_result_t              exp;
  } directed_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            start_i = 1'b0;
  logic                            busy_o;
  logic                            action_i = wdsa_pkg::ACT_EVENT;
  logic [wdsa_pkg::NOW_W-1:0]      now_i = '0;
  logic [wdsa_pkg::SRC_PORT_W-1:0] source_address_i = '0;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [wdsa_pkg::TIMEOUT_W-1:0]  cfg_data_i = wdsa_pkg::TIMEOUT_RESET;
  logic                            done_o;
  logic                            alarm_o;
  logic [wdsa_pkg::OUT_CNT_W-1:0]  entry_count_o;
  logic                            event_added_o;
  logic [wdsa_pkg::OUT_CNT_W-1:0]  expired_removed_o;

  // typed expectation for table rows, driven alongside the request
  logic                  pin_use = 1'b0;
  alarm_result_t         pin_result = '0;

  windowed_distinct_source_alarm dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .action_i          (action_i),
    .now_i             (now_i),
    .source_address_i  (source_address_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .done_o            (done_o),
    .alarm_o           (alarm_o),
    .entry_count_o     (entry_count_o),
    .event_added_o     (event_added_o),
    .expired_removed_o (expired_removed_o)
  );

  initial forever #5 clk_i = ~clk_i;

  // history predictor state
  logic [wdsa_pkg::NOW_W-1:0]      hist_time [HDEPTH];
  logic [wdsa_pkg::SRC_PORT_W-1:0] hist_src [HDEPTH];
  int unsigned                     hist_count = 0;
  logic [wdsa_pkg::NOW_W-1:0]      last_seen = '0;
  logic                            alarm_state = 1'b0;
  logic [wdsa_pkg::TIMEOUT_W-1:0]  timeout_cfg = wdsa_pkg::TIMEOUT_RESET;

  alarm_result_t expected_results [$];
  int unsigned   failures = 0;
  int unsigned   results_seen = 0;
  int unsigned   events_sent = 0;
  int unsigned   checks_sent = 0;
  int unsigned   expiries_seen = 0;
  int unsigned   cycle_count = 0;

  function automatic alarm_result_t predict_alarm(logic act,
                                                  logic [wdsa_pkg::NOW_W-1:0] at_tick,
                                                  logic [wdsa_pkg::SRC_PORT_W-1:0] src);
    alarm_result_t              r;
    int unsigned                kept;
    int unsigned                dropped;
    bit                         present;
    logic [wdsa_pkg::NOW_W-1:0] age;
    r = '0;
    kept = 0;
    dropped = 0;
    present = 1'b0;
    if (act == wdsa_pkg::ACT_EVENT) begin
      last_seen = at_tick;
      for (int i = 0; i < hist_count; i++) begin
        age = at_tick - hist_time[i];
        if (age > {1'b0, timeout_cfg}) begin
          dropped++;
        end else begin
          hist_time[kept] = hist_time[i];
          hist_src[kept] = hist_src[i];
          kept++;
        end
      end
      hist_count = kept;
      for (int i = 0; i < hist_count; i++) begin
        if (hist_src[i] == src) present = 1'b1;
      end
      if (!present && hist_count < HDEPTH) begin
        hist_time[hist_count] = at_tick;
        hist_src[hist_count] = src;
        hist_count++;
        r.event_added = 1'b1;
      end
      if (hist_count >= HDEPTH) alarm_state = 1'b1;
    end else begin
      age = at_tick - last_seen;
      if (hist_count > 0 && age > {1'b0, timeout_cfg}) alarm_state = 1'b0;
    end
    expiries_seen += dropped;
    r.alarm = alarm_state;
    r.entry_count = 2'(hist_count);
    r.expired_removed = 2'(dropped);
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("** windowed_distinct_source_alarm: FAILED **");
      $finish;
    end
  end

  // results are checked before this edge's request is predicted
  always @(posedge clk_i) begin : result_check
    alarm_result_t got;
    alarm_result_t want;
    alarm_result_t calc;
    if (rst_ni) begin
      if (done_o) begin
        got.alarm = alarm_o;
        got.entry_count = entry_count_o;
        got.event_added = event_added_o;
        got.expired_removed = expired_removed_o;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result strobe with no request outstanding");
          failures++;
        end else begin
          want = expected_results.pop_front();
          if (got.alarm !== want.alarm) begin
            $error("alarm: expected %0d, got %0d", want.alarm, got.alarm);
            failures++;
          end
          if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
            failures++;
          end
          if (got.event_added !== want.event_added) begin
            $error("event_added: expected %0d, got %0d", want.event_added, got.event_added);
            failures++;
          end
          if (got.expired_removed !== want.expired_removed) begin
            $error("expired_removed: expected %0d, got %0d",
                   want.expired_removed, got.expired_removed);
            failures++;
          end
        end
      end
      if (start_i && !busy_o) begin
        if (action_i == wdsa_pkg::ACT_EVENT) events_sent++;
        else checks_sent++;
        calc = predict_alarm(action_i, now_i, source_address_i);
        expected_results.push_back(pin_use ? pin_result : calc);
      end
      if (cfg_valid_i && cfg_ready_o) timeout_cfg = cfg_data_i;
    end
  end

  task automatic send_request(logic act, logic [wdsa_pkg::NOW_W-1:0] at_tick,
                              logic [wdsa_pkg::SRC_PORT_W-1:0] src, int unsigned gap,
                              logic pin, alarm_result_t pinned);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    action_i <= act;
    now_i <= at_tick;
    source_address_i <= src;
    pin_use <= pin;
    pin_result <= pinned;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic drain_and_settle();
    start_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_timeout(logic [wdsa_pkg::TIMEOUT_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // default timeout 3840 throughout the table
  directed_row_t plan [20] = '{
    '{wdsa_pkg::ACT_CHECK, 32'd0,         16'h0000, 1'b1, '{1'b0, 2'd0, 1'b0, 2'd0}},
    '{wdsa_pkg::ACT_EVENT, 32'd100,       16'h0000, 1'b1, '{1'b0, 2'd1, 1'b1, 2'd0}},
    '{wdsa_pkg::ACT_EVENT, 32'd200,       16'h0000, 1'b1, '{1'b0, 2'd1, 1'b0, 2'd0}},
    '{wdsa_pkg::ACT_EVENT, 32'd300,       16'hFFFF, 1'b1, '{1'b0, 2'd2, 1'b1, 2'd0}},
    '{wdsa_pkg::ACT_EVENT, 32'd400,       16'h1234, 1'b1, '{1'b1, 2'd3, 1'b1, 2'd0}},
    '{wdsa_pkg::ACT_EVENT, 32'd500,       16'hABCD, 1'b1, '{1'b1, 2'd3, 1'b0, 2'd0}},
    '{wdsa_pkg::ACT_CHECK, 32'd600,       16'h0000, 1'b1, '{1'b1, 2'd3, 1'b0, 2'd0}},
    '{wdsa_pkg::ACT_CHECK, 32'd4341,      16'hFFFF, 1'b1, '{1'b0, 2'd3, 1'b0, 2'd0}},
    '{wdsa_pkg::ACT_EVENT, 32'd3940,      16'h5555, 1'b0, '0},
    '{wdsa_pkg::ACT_EVENT, 32'd4041,      16'h0000, 1'b0, '0},
    '{wdsa_pkg::ACT_EVENT, 32'hFFFF_FF00, 16'h8001, 1'b1, '{1'b1, 2'd1, 1'b1, 2'd3}},
    '{wdsa_pkg::ACT_EVENT, 32'h0000_0010, 16'hFFFF, 1'b0, '0},
    '{wdsa_pkg::ACT_EVENT, 32'h0000_0010, 16'h8001, 1'b0, '0},
    '{wdsa_pkg::ACT_CHECK, 32'h0000_0F11, 16'h0000, 1'b0, '0},
    '{wdsa_pkg::ACT_EVENT, 32'h7FFF_FFFF, 16'h0001, 1'b0, '0},
    '{wdsa_pkg::ACT_EVENT, 32'h7FFF_FFFF, 16'hFFFE, 1'b0, '0},
    '{wdsa_pkg::ACT_EVENT, 32'h8000_0000, 16'h0001, 1'b0, '0},
    '{wdsa_pkg::ACT_EVENT, 32'h8000_0000, 16'h00FF, 1'b0, '0},
    '{wdsa_pkg::ACT_CHECK, 32'h8000_0F00, 16'h0000, 1'b0, '0},
    '{wdsa_pkg::ACT_CHECK, 32'h8000_0F01, 16'h0000, 1'b0, '0}
  };

  // sender idle percentage per phase; the result side has no stall to apply
  int unsigned phase_idle [PHASES] = '{0, 59, 0, 13, 59, 0};

  initial begin : stimulus
    logic [wdsa_pkg::SRC_PORT_W-1:0] src_pool [5];
    logic [wdsa_pkg::NOW_W-1:0]      clock_now;
    logic [wdsa_pkg::NOW_W-1:0]      step;
    logic [wdsa_pkg::SRC_PORT_W-1:0] src;
    logic                            act;
    int unsigned                     tmo;
    int unsigned                     pick;
    int unsigned                     gap;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      send_request(plan[i].action, plan[i].now, plan[i].src, 0, plan[i].pinned, plan[i].exp);
    end
    pin_use <= 1'b0;
    drain_and_settle();

    clock_now = $urandom;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: tmo = 32'h7FFF_FFFF;
        1: tmo = 1;
        2: tmo = $urandom_range(2, 200);
        3: tmo = 32'(wdsa_pkg::TIMEOUT_RESET);
        4: tmo = $urandom_range(1, 32'h7FFF_FFFF);
        default: tmo = $urandom_range(16, 5000);
      endcase
      write_timeout(wdsa_pkg::TIMEOUT_W'(tmo));
      foreach (src_pool[k]) src_pool[k] = 16'($urandom);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        act = ($urandom_range(0, 99) < 25) ? wdsa_pkg::ACT_CHECK : wdsa_pkg::ACT_EVENT;
        // time moves mostly within the window so the history fills up
        pick = $urandom_range(0, 99);
        if (pick < 70) step = $urandom_range(0, tmo / 3);
        else if (pick < 92) step = $urandom_range(tmo / 2, tmo + tmo / 2 + 1);
        else if (pick < 97) step = tmo + $urandom_range(0, 1);
        else step = $urandom;
        clock_now = clock_now + step;
        src = ($urandom_range(0, 99) < 85) ? src_pool[$urandom_range(0, 4)]
                                           : 16'($urandom);
        gap = ($urandom_range(0, 99) < phase_idle[p]) ? $urandom_range(1, 6) : 0;
        send_request(act, clock_now, src, gap, 1'b0, '0);
      end
      drain_and_settle();
    end

    $display("Ran %0d event and %0d check requests across %0d timeout settings,",
             events_sent, checks_sent, PHASES + 1);
    $display("%0d results compared, %0d history entries expired along the way.",
             results_seen, expiries_seen);
    if (failures == 0) begin
      $display("** windowed_distinct_source_alarm: PASSED **");
    end else begin
      $display("** windowed_distinct_source_alarm: FAILED **");
    end
    $finish;
  end

endmodule

/* windowed_distinct_source_alarm.f */
design/wdsa_pkg.sv
design/wdsa_age_cmp.sv
design/wdsa_hist.sv
design/windowed_distinct_source_alarm.sv
test/windowed_distinct_source_alarm_test.sv
